### design/rc_pkg.sv
// Shared types and constants for the radix converter.
`timescale 1ns / 1ps

package rc_pkg;

    // Configuration register map
    localparam int CFG_AW = 3;
    localparam logic REG_RADIX    = 1'b0;
    localparam logic REG_MAX_FRAC = 1'b1;

    localparam logic [4:0] RADIX_RESET    = 5'd10;
    localparam logic [4:0] MAX_FRAC_RESET = 5'd16;
    localparam logic [4:0] RADIX_MIN      = 5'd2;
    localparam logic [4:0] RADIX_MAX      = 5'd16;

    typedef enum logic {
        ALU_DIV,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        t_alu_op    op;
        logic [4:0] base;
    } t_alu_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_IRD,
        S_IOUT,
        S_FMUL,
        S_FOUT
    } t_state;

endpackage

### design/rc_alu.sv
// Shared arithmetic unit: one restoring-division step or one fraction multiply by the base.
`timescale 1ns / 1ps

module rc_alu #(
    parameter int QW = 32
) (
    input  rc_pkg::t_alu_req i_req,
    input  logic [QW-1:0]    i_quot,
    input  logic [3:0]       i_rem,
    input  logic [31:0]      i_frac,
    output logic [QW-1:0]    o_quot,
    output logic [3:0]       o_rem,
    output logic [31:0]      o_frac,
    output logic [3:0]       o_digit
);
    import rc_pkg::*;

    logic [4:0]  w_trial;
    logic        w_ge;
    logic [4:0]  w_diff;
    logic [35:0] w_prod;

    // shift next dividend bit into the partial remainder, subtract if it fits
    assign w_trial = {i_rem, i_quot[QW-1]};
    assign w_ge    = (w_trial >= i_req.base);
    assign w_diff  = w_trial - i_req.base;
    assign o_quot  = {i_quot[QW-2:0], w_ge};
    assign o_rem   = w_ge ? w_diff[3:0] : w_trial[3:0];

    // base <= 16, so the product of a Q0.32 value fits in 36 bits
    assign w_prod  = 36'(i_frac) * 36'(i_req.base);
    assign o_frac  = w_prod[31:0];

    always_comb begin
        unique case (i_req.op)
            ALU_DIV: o_digit = o_rem;
            ALU_MUL: o_digit = w_prod[35:32];
            default: o_digit = o_rem;
        endcase
    end

endmodule

### design/rc_dstore.sv
// Integer digit store, least significant digit first, registered read.
`timescale 1ns / 1ps

module rc_dstore #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [3:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [3:0]    o_rdata
);
    logic [3:0] r_mem [DEPTH];
    logic [3:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/radix_converter.sv
// Radix converter top level: config registers, sequencer, stream ports.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+---------------------------------------
//   s_*      | in  | s_tvalid / s_tready    | tdata: integer_part, fraction_part
//   m_*      | out | m_tvalid / m_tready    | tdata: digit; tuser: in_fraction; tlast
//   apb      | in  | psel,penable,pready    | paddr 0: radix, 4: max_fraction_digits
//
// Each integer digit is produced by restoring divide steps on the shared ALU, one
// per quotient bit; each integer digit out is a store read, then output, and each
// fraction digit is a multiply, then output; output stalls hold the sequence.
// s_tready is high only when idle.
// Synchronous active-low reset returns to idle with registers at 10 and 16.
`timescale 1ns / 1ps

module radix_converter #(
    parameter int INT_BITS        = 32,
    parameter int FRAC_DIGITS_MAX = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // [31:0] integer_part, [63:32] fraction_part
    // master stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [3:0] digit, [7:4] zero
    output logic                        m_tuser,   // [0] in_fraction
    output logic                        m_tlast,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rc_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import rc_pkg::*;

    localparam int QW = (INT_BITS < 32) ? INT_BITS : 32;
    localparam int AW = $clog2(QW);
    localparam int CW = $clog2(QW + 1);
    localparam int BW = $clog2(QW);
    localparam int LW = $clog2(FRAC_DIGITS_MAX + 1);

    // configuration
    logic [4:0] r_radix;
    logic [4:0] r_max_frac;
    logic       w_cfg_wr;
    logic       w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= RADIX_RESET;
            r_max_frac <= MAX_FRAC_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_RADIX:    r_radix    <= pwdata[4:0];
                REG_MAX_FRAC: r_max_frac <= pwdata[4:0];
                default:      r_radix    <= r_radix;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_RADIX:    prdata = {27'd0, r_radix};
            REG_MAX_FRAC: prdata = {27'd0, r_max_frac};
            default:      prdata = 32'd0;
        endcase
    end

    // sequencer state
    t_state         r_state, n_state;
    logic [QW-1:0]  r_quot,  n_quot;
    logic [3:0]     r_rem,   n_rem;
    logic [BW-1:0]  r_bit,   n_bit;
    logic [CW-1:0]  r_cnt,   n_cnt;
    logic [31:0]    r_frac,  n_frac;
    logic [3:0]     r_fdig,  n_fdig;
    logic           r_last,  n_last;
    logic [LW-1:0]  r_nfrac, n_nfrac;
    logic [LW-1:0]  r_limit, n_limit;
    logic [4:0]     r_base,  n_base;

    t_alu_req       w_req;
    logic [QW-1:0]  w_alu_quot;
    logic [3:0]     w_alu_rem;
    logic [31:0]    w_alu_frac;
    logic [3:0]     w_alu_digit;
    logic [CW-1:0]  w_cnt_dec;
    logic [LW-1:0]  w_nfrac_inc;
    logic [5:0]     w_lim_ext;
    logic [4:0]     w_base_clamp;
    logic [LW-1:0]  w_lim_clamp;
    logic           w_in_acc;
    logic           w_out_acc;
    logic           w_div_last;
    logic           w_we;
    logic           w_re;
    logic [3:0]     w_rdata;

    assign w_in_acc    = s_tvalid && s_tready;
    assign w_out_acc   = m_tvalid && m_tready;
    assign w_cnt_dec   = r_cnt - CW'(1);
    assign w_nfrac_inc = r_nfrac + LW'(1);
    assign w_div_last  = (r_bit == BW'(QW - 1));
    assign w_lim_ext   = {1'b0, r_max_frac};

    always_comb begin
        if (r_radix < RADIX_MIN) begin
            w_base_clamp = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            w_base_clamp = RADIX_MAX;
        end else begin
            w_base_clamp = r_radix;
        end
        if (w_lim_ext == 6'd0) begin
            w_lim_clamp = LW'(1);
        end else if (w_lim_ext > 6'(FRAC_DIGITS_MAX)) begin
            w_lim_clamp = LW'(FRAC_DIGITS_MAX);
        end else begin
            w_lim_clamp = LW'(w_lim_ext);
        end
    end

    assign w_req.op   = (r_state == S_FMUL) ? ALU_MUL : ALU_DIV;
    assign w_req.base = r_base;

    rc_alu #(
        .QW (QW)
    ) u_alu (
        .i_req   (w_req),
        .i_quot  (r_quot),
        .i_rem   (r_rem),
        .i_frac  (r_frac),
        .o_quot  (w_alu_quot),
        .o_rem   (w_alu_rem),
        .o_frac  (w_alu_frac),
        .o_digit (w_alu_digit)
    );

    assign w_we = (r_state == S_DIV) && w_div_last;
    assign w_re = (r_state == S_IRD);

    rc_dstore #(
        .DEPTH (QW),
        .AW    (AW)
    ) u_dstore (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_alu_digit),
        .i_re    (w_re),
        .i_raddr (w_cnt_dec[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        n_frac  = r_frac;
        n_fdig  = r_fdig;
        n_last  = r_last;
        n_nfrac = r_nfrac;
        n_limit = r_limit;
        n_base  = r_base;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_quot  = s_tdata[QW-1:0];
                    n_frac  = s_tdata[63:32];
                    n_rem   = 4'd0;
                    n_bit   = '0;
                    n_cnt   = '0;
                    n_nfrac = '0;
                    n_base  = w_base_clamp;
                    n_limit = w_lim_clamp;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quot = w_alu_quot;
                n_rem  = w_alu_rem;
                n_bit  = r_bit + BW'(1);
                if (w_div_last) begin
                    // digit written to the store this edge; start the next division
                    n_rem = 4'd0;
                    n_bit = '0;
                    n_cnt = r_cnt + CW'(1);
                    if (w_alu_quot == '0) begin
                        n_state = S_IRD;
                    end
                end
            end
            S_IRD: begin
                n_state = S_IOUT;
            end
            S_IOUT: begin
                if (w_out_acc) begin
                    n_cnt = w_cnt_dec;
                    n_state = (w_cnt_dec == '0) ? S_FMUL : S_IRD;
                end
            end
            S_FMUL: begin
                n_frac  = w_alu_frac;
                n_fdig  = w_alu_digit;
                n_nfrac = w_nfrac_inc;
                n_last  = (w_alu_frac == 32'd0) || (w_nfrac_inc >= r_limit);
                n_state = S_FOUT;
            end
            S_FOUT: begin
                if (w_out_acc) begin
                    n_state = r_last ? S_IDLE : S_FMUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
            r_cnt   <= '0;
            r_nfrac <= '0;
            r_quot  <= '0;
            r_frac  <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_cnt   <= n_cnt;
            r_nfrac <= n_nfrac;
            r_quot  <= n_quot;
            r_frac  <= n_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_fdig  <= n_fdig;
        r_last  <= n_last;
        r_limit <= n_limit;
        r_base  <= n_base;
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = (r_state == S_IOUT) || (r_state == S_FOUT);
    assign m_tdata  = {4'd0, (r_state == S_FOUT) ? r_fdig : w_rdata};
    assign m_tuser  = (r_state == S_FOUT);
    assign m_tlast  = (r_state == S_FOUT) && r_last;

`ifndef SYNTHESIS
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !m_tvalid)
        else $error("output valid while idle");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready after accepting a transaction");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("not idle after final digit");

    a_last_is_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("last marked on an integer digit");
`endif

endmodule
